@@ sv/pwr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pwr_pkg
// Shared constants, register indexes and types of the PID block with a
// periodic window reset.
// ----------------------------------------------------------------------------
package pwr_pkg;

   localparam int SAMPLE_WIDTH_DEF = 24;
   localparam int GAIN_WIDTH       = 16;
   localparam int CSR_DATA_WIDTH   = 16;
   localparam int CSR_INDEX_WIDTH  = 3;
   localparam int COUNT_WIDTH      = 16;
   localparam int DRIVE_WIDTH      = 32;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GAIN_PROP     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GAIN_INTEGRAL = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GAIN_DERIV    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DIVISOR       = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_WINDOW_LENGTH = 3'd4;

   // Item opcodes.
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   // Control of the shared multiply-accumulate unit.
   typedef struct packed {
      logic clear;
      logic mul_en;
   } mac_ctrl_type;

endpackage : pwr_pkg
`default_nettype wire

@@ sv/pwr_req_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pwr_req_if
// Input item channel: opcode and error sample with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pwr_req_if #(
   parameter int SAMPLE_WIDTH = pwr_pkg::SAMPLE_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic                           opcode;
   logic signed [SAMPLE_WIDTH-1:0] sample;

   modport source (output valid, output opcode, output sample, input ready);
   modport sink   (input valid, input opcode, input sample, output ready);
endinterface : pwr_req_if
`default_nettype wire

@@ sv/pwr_rsp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pwr_rsp_if
// Result channel: saturated drive value and window-cleared flag.
// ----------------------------------------------------------------------------
interface pwr_rsp_if;
   import pwr_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [DRIVE_WIDTH-1:0] drive;
   logic                          window_cleared;

   modport source (output valid, output drive, output window_cleared, input ready);
   modport sink   (input valid, input drive, input window_cleared, output ready);
endinterface : pwr_rsp_if
`default_nettype wire

@@ sv/pwr_csr_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pwr_csr_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface pwr_csr_if;
   import pwr_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface : pwr_csr_if
`default_nettype wire

@@ sv/pwr_mac.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pwr_mac
// Shared signed multiply-accumulate unit. One product per enabled cycle is
// registered, then added into the accumulator on the following cycle.
// ----------------------------------------------------------------------------
module pwr_mac #(
   parameter int A_WIDTH   = 40,
   parameter int ACC_WIDTH = 58
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  pwr_pkg::mac_ctrl_type                    ctrl,
   input  logic signed [A_WIDTH-1:0]                op_a,
   input  logic signed [pwr_pkg::GAIN_WIDTH-1:0]    op_b,
   output logic signed [ACC_WIDTH-1:0]              acc
);
   import pwr_pkg::*;

   localparam int P_WIDTH = A_WIDTH + GAIN_WIDTH;

   logic signed [P_WIDTH-1:0]   prod_ff;
   logic signed [P_WIDTH-1:0]   prod_in;
   logic                        prod_vld_ff;
   logic signed [ACC_WIDTH-1:0] acc_ff;
   logic signed [ACC_WIDTH-1:0] acc_in;

   assign prod_in = P_WIDTH'(op_a) * P_WIDTH'(op_b);

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_WIDTH'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         acc_ff      <= '0;
      end else begin
         prod_vld_ff <= ctrl.mul_en && !ctrl.clear;
         acc_ff      <= acc_in;
      end
      prod_ff <= prod_in;
   end

   assign acc = acc_ff;

endmodule : pwr_mac
`default_nettype wire

@@ sv/pwr_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pwr_div
// Iterative rounding divider: adds half the divisor with the sign of the
// dividend, divides magnitudes one quotient bit per cycle, restores the sign
// and saturates the quotient to 32 bits.
// ----------------------------------------------------------------------------
module pwr_div #(
   parameter int SUM_WIDTH = 58
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   input  logic signed [SUM_WIDTH-1:0]              sum,
   input  logic [pwr_pkg::CSR_DATA_WIDTH-1:0]       divisor,
   output logic                                     done,
   output logic signed [pwr_pkg::DRIVE_WIDTH-1:0]   drive
);
   import pwr_pkg::*;

   localparam int NW = SUM_WIDTH + 1;
   localparam int DW = CSR_DATA_WIDTH;
   localparam int CW = $clog2(NW);

   typedef enum logic [1:0] {
      S_IDLE,
      S_ABS,
      S_ITER,
      S_FIN
   } state_type;

   state_type               state_ff;
   logic signed [NW-1:0]    num_ff;
   logic signed [NW-1:0]    num_in;
   logic [NW-1:0]           quo_ff;
   logic [DW-1:0]           rem_ff;
   logic [DW-1:0]           den_ff;
   logic [DW-1:0]           den_in;
   logic [CW-1:0]           cnt_ff;
   logic                    neg_ff;
   logic                    done_ff;
   logic signed [DRIVE_WIDTH-1:0] drive_ff;
   logic signed [DRIVE_WIDTH-1:0] drive_in;
   logic [DW:0]             rem_sh;
   logic                    fits;
   logic signed [NW-1:0]    half;
   logic                    pos_over;
   logic                    neg_over;

   assign den_in = (divisor == '0) ? DW'(1) : divisor;
   assign half   = NW'({1'b0, den_in[DW-1:1]});
   assign num_in = sum[SUM_WIDTH-1] ? (NW'(sum) - half) : (NW'(sum) + half);

   assign rem_sh = {rem_ff, quo_ff[NW-1]};
   assign fits   = rem_sh >= {1'b0, den_ff};

   // Saturation is judged on the magnitude; only its low 32 bits are negated here.
   assign pos_over = |quo_ff[NW-1:DRIVE_WIDTH-1];
   assign neg_over = (|quo_ff[NW-1:DRIVE_WIDTH])
                     || (quo_ff[DRIVE_WIDTH-1] && (|quo_ff[DRIVE_WIDTH-2:0]));

   always_comb begin
      if (neg_ff) begin
         drive_in = neg_over ? {1'b1, {(DRIVE_WIDTH-1){1'b0}}}
                             : -$signed(quo_ff[DRIVE_WIDTH-1:0]);
      end else begin
         drive_in = pos_over ? {1'b0, {(DRIVE_WIDTH-1){1'b1}}}
                             : $signed(quo_ff[DRIVE_WIDTH-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  state_ff <= S_ABS;
               end
            end
            S_ABS: begin
               state_ff <= S_ITER;
            end
            S_ITER: begin
               if (cnt_ff == '0) begin
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               done_ff  <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               num_ff <= num_in;
               den_ff <= den_in;
            end
         end
         S_ABS: begin
            neg_ff <= num_ff[NW-1];
            quo_ff <= num_ff[NW-1] ? NW'(-num_ff) : NW'(num_ff);
            rem_ff <= '0;
            cnt_ff <= CW'(NW - 1);
         end
         S_ITER: begin
            if (fits) begin
               rem_ff <= DW'(rem_sh - {1'b0, den_ff});
            end else begin
               rem_ff <= rem_sh[DW-1:0];
            end
            quo_ff <= {quo_ff[NW-2:0], fits};
            cnt_ff <= cnt_ff - 1'b1;
         end
         S_FIN: begin
            drive_ff <= drive_in;
         end
         default: begin
         end
      endcase
   end

   assign done  = done_ff;
   assign drive = drive_ff;

endmodule : pwr_div
`default_nettype wire

@@ sv/pid_with_window_reset.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pid_with_window_reset
// One item is in work at a time: an accepted item passes three times through the
// shared multiplier, then through the restoring divider, one quotient bit per
// cycle over SAMPLE_WIDTH + 35 bits, and its result goes to the output register.
// A new item is taken once the previous result sits in the output register and
// no register write waits. Reset (synchronous, active high) clears terms, count,
// gains to 0, and divisor and window length to 1; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pid_with_window_reset #(
   parameter int SAMPLE_WIDTH = pwr_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic   clock,
   input  logic   reset,
   pwr_req_if.sink   req_ch,
   pwr_rsp_if.source rsp_ch,
   pwr_csr_if.sink   csr_ch
);
   import pwr_pkg::*;

   // Integral term is 40 bits at the default sample width.
   localparam int IW   = SAMPLE_WIDTH + 16;
   localparam int DTW  = SAMPLE_WIDTH + 1;
   localparam int SUMW = IW + GAIN_WIDTH + 2;

   typedef enum logic [2:0] {
      T_IDLE,
      T_MUL,
      T_DIV_GO,
      T_WAIT,
      T_PUSH
   } state_type;

   state_type                       state_ff;
   logic [1:0]                      step_ff;

   // Configuration registers.
   logic signed [GAIN_WIDTH-1:0]    gain_prop_ff;
   logic signed [GAIN_WIDTH-1:0]    gain_integral_ff;
   logic signed [GAIN_WIDTH-1:0]    gain_deriv_ff;
   logic [CSR_DATA_WIDTH-1:0]       divisor_ff;
   logic [CSR_DATA_WIDTH-1:0]       window_len_ff;

   // Controller terms.
   logic signed [SAMPLE_WIDTH-1:0]  prop_ff;
   logic signed [SAMPLE_WIDTH-1:0]  prop_in;
   logic signed [IW-1:0]            integ_ff;
   logic signed [IW-1:0]            integ_in;
   logic signed [DTW-1:0]           deriv_ff;
   logic signed [DTW-1:0]           deriv_in;
   logic [COUNT_WIDTH-1:0]          count_ff;
   logic [COUNT_WIDTH-1:0]          count_inc;
   logic                            clear_now;
   logic                            cleared_ff;

   // Output register.
   logic                            rsp_valid_ff;
   logic signed [DRIVE_WIDTH-1:0]   rsp_drive_ff;
   logic                            rsp_cleared_ff;

   logic                            req_ready;
   logic                            csr_ready;
   logic                            req_fire;
   logic                            csr_fire;
   logic                            slot_free;

   mac_ctrl_type                    mac_ctrl;
   logic signed [IW-1:0]            mac_a;
   logic signed [GAIN_WIDTH-1:0]    mac_b;
   logic signed [SUMW-1:0]          mac_acc;
   logic                            div_done;
   logic signed [DRIVE_WIDTH-1:0]   div_drive;

   // Register writes are taken only between items, and they win over a
   // waiting item so that the two never land on the same edge.
   assign csr_ready    = (state_ff == T_IDLE);
   assign req_ready    = (state_ff == T_IDLE) && !csr_ch.valid;
   assign req_fire     = req_ch.valid && req_ready;
   assign csr_fire     = csr_ch.valid && csr_ready;
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready = req_ready;
   assign csr_ch.ready = csr_ready;

   // A sample becomes the proportional term, its difference from the old one the
   // derivative, and it adds itself to the integral. Reaching the window length,
   // or a clear item, zeroes every term and the count instead.
   assign count_inc = count_ff + 1'b1;
   assign clear_now = (req_ch.opcode == OP_CLEAR) || (count_inc >= window_len_ff);
   assign prop_in   = req_ch.sample;
   assign deriv_in  = DTW'(req_ch.sample) - DTW'(prop_ff);
   assign integ_in  = integ_ff + IW'(req_ch.sample);

   // Sequencer step k feeds term k and its gain into the shared multiplier.
   always_comb begin
      case (step_ff)
         2'd0: begin
            mac_a = IW'(prop_ff);
            mac_b = gain_prop_ff;
         end
         2'd1: begin
            mac_a = integ_ff;
            mac_b = gain_integral_ff;
         end
         2'd2: begin
            mac_a = IW'(deriv_ff);
            mac_b = gain_deriv_ff;
         end
         default: begin
            mac_a = '0;
            mac_b = '0;
         end
      endcase
      mac_ctrl.clear  = req_fire;
      mac_ctrl.mul_en = (state_ff == T_MUL) && (step_ff != 2'd3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= T_IDLE;
         step_ff          <= '0;
         gain_prop_ff     <= '0;
         gain_integral_ff <= '0;
         gain_deriv_ff    <= '0;
         divisor_ff       <= CSR_DATA_WIDTH'(1);
         window_len_ff    <= CSR_DATA_WIDTH'(1);
         prop_ff          <= '0;
         integ_ff         <= '0;
         deriv_ff         <= '0;
         count_ff         <= '0;
         cleared_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         // A write to any of the five defined registers restarts the window count; the terms are kept.
         if (csr_fire) begin
            case (csr_ch.index)
               REG_GAIN_PROP: begin
                  gain_prop_ff <= csr_ch.data;
                  count_ff     <= '0;
               end
               REG_GAIN_INTEGRAL: begin
                  gain_integral_ff <= csr_ch.data;
                  count_ff         <= '0;
               end
               REG_GAIN_DERIV: begin
                  gain_deriv_ff <= csr_ch.data;
                  count_ff      <= '0;
               end
               REG_DIVISOR: begin
                  divisor_ff <= csr_ch.data;
                  count_ff   <= '0;
               end
               REG_WINDOW_LENGTH: begin
                  window_len_ff <= csr_ch.data;
                  count_ff      <= '0;
               end
               default: begin
               end
            endcase
         end

         // The output register fills from the push state and empties when
         // the receiver takes the beat.
         if ((state_ff == T_PUSH) && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            T_IDLE: begin
               if (req_fire) begin
                  if (clear_now) begin
                     prop_ff  <= '0;
                     integ_ff <= '0;
                     deriv_ff <= '0;
                     count_ff <= '0;
                  end else begin
                     prop_ff  <= prop_in;
                     integ_ff <= integ_in;
                     deriv_ff <= deriv_in;
                     count_ff <= count_inc;
                  end
                  cleared_ff <= clear_now;
                  step_ff    <= '0;
                  state_ff   <= T_MUL;
               end
            end
            T_MUL: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == 2'd3) begin
                  state_ff <= T_DIV_GO;
               end
            end
            T_DIV_GO: begin
               state_ff <= T_WAIT;
            end
            T_WAIT: begin
               if (div_done) begin
                  state_ff <= T_PUSH;
               end
            end
            T_PUSH: begin
               if (slot_free) begin
                  state_ff <= T_IDLE;
               end
            end
            default: begin
               state_ff <= T_IDLE;
            end
         endcase
      end

      if ((state_ff == T_PUSH) && slot_free) begin
         rsp_drive_ff   <= div_drive;
         rsp_cleared_ff <= cleared_ff;
      end
   end

   pwr_mac #(
      .A_WIDTH   (IW),
      .ACC_WIDTH (SUMW)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .acc   (mac_acc)
   );

   pwr_div #(
      .SUM_WIDTH (SUMW)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (state_ff == T_DIV_GO),
      .sum     (mac_acc),
      .divisor (divisor_ff),
      .done    (div_done),
      .drive   (div_drive)
   );

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.drive          = rsp_drive_ff;
   assign rsp_ch.window_cleared = rsp_cleared_ff;

   // An item that cleared its terms always produces a zero drive beat.
   a_cleared_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_cleared_ff |-> rsp_drive_ff == '0)
      else $error("cleared item produced a nonzero drive");

   // The divider only finishes while the sequencer waits for it.
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == T_WAIT)
      else $error("divider finished outside the wait state");

   // The window count never rests at or above a nonzero window length.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      window_len_ff != '0 |-> count_ff < window_len_ff)
      else $error("sample count reached the window length");

endmodule : pid_with_window_reset
`default_nettype wire
